@@ hdl/last_hop_table_best_route_macros.svh @@
// assertion macros for the last-hop table rtl
// no dependencies
`ifndef LAST_HOP_TABLE_BEST_ROUTE_MACROS_SVH
`define LAST_HOP_TABLE_BEST_ROUTE_MACROS_SVH

// same-cycle implication
`define LHTBR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lhtbr assertion failed");

// next-cycle implication
`define LHTBR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lhtbr assertion failed");

`endif

@@ hdl/lhtbr_pkg.sv @@
// types, codes and defaults for the last-hop table
// no dependencies
`timescale 1ns / 1ps

package lhtbr_pkg;

  localparam int DEF_MAX_DEVICES = 16;
  localparam int DEF_MAX_HOPS    = 8;

  localparam int ID_W = 16;
  localparam int Q_W  = 8;

  localparam logic [2:0] CMD_ADD_IN     = 3'd0;
  localparam logic [2:0] CMD_ADD_OUT    = 3'd1;
  localparam logic [2:0] CMD_FIND       = 3'd2;
  localparam logic [2:0] CMD_FIND_FIRST = 3'd3;
  localparam logic [2:0] CMD_REMOVE     = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [0:0] REG_IN_LIMIT  = 1'b0;
  localparam logic [0:0] REG_OUT_LIMIT = 1'b1;

  localparam logic [Q_W-1:0] LIMIT_RESET = 8'h7F;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] bus;
    logic [Q_W-1:0]  q;
  } hop_t;

endpackage

@@ hdl/lhtbr_hop_ram.sv @@
// one hop-record memory, one write and one registered read per cycle
// depends on lhtbr_pkg
`timescale 1ns / 1ps

module lhtbr_hop_ram
  import lhtbr_pkg::*;
#(
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  hop_t          wdata,
  input  logic [AW-1:0] raddr,
  output hop_t          rdata
);

  hop_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/last_hop_table_best_route.sv @@
// top level of the last-hop table: command sequencer, device directory memory
// depends on lhtbr_pkg, lhtbr_hop_ram and the macros header
`timescale 1ns / 1ps
`include "last_hop_table_best_route_macros.svh"

// One command is taken at a time; the result word sits in an output register
// so the next command can be taken while it waits. Each memory access is split
// into an address state and a state that uses the registered data. Device lookup
// walks the directory memory device by device. Add: lookup, then a check of each
// stored hop and an append, or lookup and a slot claim for a new device. Find:
// lookup, then a read of each incoming hop, plus a read of each outgoing hop for
// each admissible incoming hop. Remove: lookup, then each later device moved up.
// Hop records are kept per physical slot and never moved; the directory keeps
// order and slot map.
module last_hop_table_best_route
  import lhtbr_pkg::*;
#(
  parameter int MAX_DEVICES = DEF_MAX_DEVICES,
  parameter int MAX_HOPS    = DEF_MAX_HOPS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [2:0]      command,
  input  logic [ID_W-1:0] device,
  input  logic [ID_W-1:0] hop_id,
  input  logic [ID_W-1:0] hop_bus_id,
  input  logic [Q_W-1:0]  quality,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      status,
  output logic [ID_W-1:0] target,
  output logic [ID_W-1:0] bus_at_target,
  output logic [ID_W-1:0] prev_id,
  output logic [ID_W-1:0] bus_at_prev,
  output logic [ID_W-1:0] next_id,
  input  logic            cfg_we,
  input  logic [0:0]      cfg_index,
  input  logic [Q_W-1:0]  cfg_data
);

  localparam int POS_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int CNT_W = $clog2(MAX_DEVICES + 1);
  localparam int HI_W  = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
  localparam int HC_W  = $clog2(MAX_HOPS + 1);
  localparam int HA_W  = POS_W + HI_W;
  localparam int OC_LO = 0;
  localparam int IC_LO = HC_W;
  localparam int SL_LO = 2 * HC_W;
  localparam int ID_LO = 2 * HC_W + POS_W;
  localparam int DIR_W = ID_LO + ID_W;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_DRD     = 14'b00000000000010,
    S_DCHK    = 14'b00000000000100,
    S_SLOT    = 14'b00000000001000,
    S_SLOTGET = 14'b00000000010000,
    S_HRD     = 14'b00000000100000,
    S_HCHK    = 14'b00000001000000,
    S_APP     = 14'b00000010000000,
    S_IRD     = 14'b00000100000000,
    S_IGET    = 14'b00001000000000,
    S_ORD     = 14'b00010000000000,
    S_OGET    = 14'b00100000000000,
    S_MRD     = 14'b01000000000000,
    S_MWR     = 14'b10000000000000
  } state_t;

  state_t state;
  logic   done;

  logic [Q_W-1:0] in_limit;
  logic [Q_W-1:0] out_limit;

  logic [2:0]      cmd;
  logic [ID_W-1:0] dev;
  logic [ID_W-1:0] hid;
  logic [ID_W-1:0] hbus;
  logic [Q_W-1:0]  hq;
  logic            any;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] hwm;
  logic [CNT_W-1:0] idx;
  logic [HC_W-1:0]  j;
  logic [HC_W-1:0]  k;

  logic [ID_W-1:0]  ent_id;
  logic [POS_W-1:0] ent_slot;
  logic [HC_W-1:0]  ent_ic;
  logic [HC_W-1:0]  ent_oc;
  logic [POS_W-1:0] pos;

  hop_t           irec;
  logic           have;
  logic [Q_W-1:0] best_i;
  logic [Q_W-1:0] best_o;

  logic [1:0]      res_status;
  logic [ID_W-1:0] res_target;
  logic [ID_W-1:0] res_bus_t;
  logic [ID_W-1:0] res_prev;
  logic [ID_W-1:0] res_bus_p;
  logic [ID_W-1:0] res_next;

  logic [DIR_W-1:0] dir_mem [2**POS_W];
  logic [DIR_W-1:0] dir_q;
  logic [POS_W-1:0] dir_raddr;
  logic             dir_we;
  logic [POS_W-1:0] dir_waddr;
  logic [DIR_W-1:0] dir_wdata;

  logic [HA_W-1:0] hop_raddr;
  logic [HA_W-1:0] hop_waddr;
  hop_t            hop_wdata;
  logic            hop_we_in;
  logic            hop_we_out;
  hop_t            in_q;
  hop_t            out_q;

  logic             in_acc;
  logic             is_out;
  logic [CNT_W-1:0] idx_inc;
  logic [HC_W-1:0]  j_inc;
  logic [HC_W-1:0]  k_inc;
  logic [HC_W-1:0]  list_n;
  logic [HC_W-1:0]  q_list_n;
  logic [POS_W-1:0] new_slot;
  logic             dir_match;
  logic             better;
  logic             have_n;

  assign in_stall  = (state != S_IDLE) || done;
  assign in_acc    = in_valid && !in_stall;
  assign is_out    = (cmd == CMD_ADD_OUT);
  assign idx_inc   = idx + CNT_W'(1);
  assign j_inc     = j + HC_W'(1);
  assign k_inc     = k + HC_W'(1);
  assign list_n    = is_out ? ent_oc : ent_ic;
  assign q_list_n  = is_out ? dir_q[OC_LO +: HC_W] : dir_q[IC_LO +: HC_W];
  assign new_slot  = (count == hwm) ? hwm[POS_W-1:0] : dir_q[SL_LO +: POS_W];
  assign dir_match = any || (dir_q[ID_LO +: ID_W] == dev);
  assign better    = (out_q.id == irec.id) && (out_q.q < out_limit) &&
                     (!have || (irec.q < best_i) ||
                      ((irec.q == best_i) && (out_q.q < best_o)));
  assign have_n    = have || better;

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    dir_q <= dir_mem[dir_raddr];
  end

  lhtbr_hop_ram #(.AW(HA_W)) u_in_ram (
    .clk(clk), .we(hop_we_in), .waddr(hop_waddr), .wdata(hop_wdata),
    .raddr(hop_raddr), .rdata(in_q)
  );

  lhtbr_hop_ram #(.AW(HA_W)) u_out_ram (
    .clk(clk), .we(hop_we_out), .waddr(hop_waddr), .wdata(hop_wdata),
    .raddr(hop_raddr), .rdata(out_q)
  );

  // memory port control per state
  always_comb begin
    dir_raddr  = '0;
    dir_we     = 1'b0;
    dir_waddr  = '0;
    dir_wdata  = '0;
    hop_raddr  = '0;
    hop_waddr  = '0;
    hop_wdata  = '{id: hid, bus: hbus, q: hq};
    hop_we_in  = 1'b0;
    hop_we_out = 1'b0;
    unique case (state)
      S_DRD: dir_raddr = idx[POS_W-1:0];
      S_SLOT: dir_raddr = count[POS_W-1:0];
      S_SLOTGET: begin
        hop_waddr  = {new_slot, HI_W'(0)};
        hop_we_in  = !is_out;
        hop_we_out = is_out;
        dir_we     = 1'b1;
        dir_waddr  = count[POS_W-1:0];
        dir_wdata  = {dev, new_slot, HC_W'(!is_out), HC_W'(is_out)};
      end
      S_HRD: hop_raddr = {ent_slot, j[HI_W-1:0]};
      S_APP: begin
        if (list_n < HC_W'(MAX_HOPS)) begin
          hop_waddr  = {ent_slot, list_n[HI_W-1:0]};
          hop_we_in  = !is_out;
          hop_we_out = is_out;
          dir_we     = 1'b1;
          dir_waddr  = pos;
          dir_wdata  = {ent_id, ent_slot,
                        is_out ? ent_ic : ent_ic + HC_W'(1),
                        is_out ? ent_oc + HC_W'(1) : ent_oc};
        end
      end
      S_IRD: hop_raddr = {ent_slot, j[HI_W-1:0]};
      S_ORD: hop_raddr = {ent_slot, k[HI_W-1:0]};
      S_MRD: begin
        if (idx_inc < count) begin
          dir_raddr = idx_inc[POS_W-1:0];
        end else begin
          // freed slot parks just past the live devices
          dir_we    = 1'b1;
          dir_waddr = idx[POS_W-1:0];
          dir_wdata = {ID_W'(0), ent_slot, HC_W'(0), HC_W'(0)};
        end
      end
      S_MWR: begin
        dir_we    = 1'b1;
        dir_waddr = idx[POS_W-1:0];
        dir_wdata = dir_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_limit  <= LIMIT_RESET;
      out_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IN_LIMIT:  in_limit  <= cfg_data;
        REG_OUT_LIMIT: out_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      count     <= '0;
      hwm       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (done && !(out_valid && out_stall)) begin
        out_valid     <= 1'b1;
        status        <= res_status;
        target        <= res_target;
        bus_at_target <= res_bus_t;
        prev_id       <= res_prev;
        bus_at_prev   <= res_bus_p;
        next_id       <= res_next;
        done          <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            cmd        <= command;
            dev        <= device;
            hid        <= hop_id;
            hbus       <= hop_bus_id;
            hq         <= quality;
            idx        <= '0;
            have       <= 1'b0;
            any        <= (command == CMD_FIND_FIRST);
            res_status <= ST_FAIL;
            res_target <= '0;
            res_bus_t  <= '0;
            res_prev   <= '0;
            res_bus_p  <= '0;
            res_next   <= '0;
            if (command > CMD_REMOVE) begin
              done <= 1'b1;
            end else if (count == '0) begin
              if (command == CMD_ADD_IN || command == CMD_ADD_OUT) begin
                state <= S_SLOT;
              end else begin
                done <= 1'b1;
              end
            end else begin
              state <= S_DRD;
            end
          end
        end
        S_DRD: state <= S_DCHK;
        S_DCHK: begin
          if (dir_match) begin
            ent_id   <= dir_q[ID_LO +: ID_W];
            ent_slot <= dir_q[SL_LO +: POS_W];
            ent_ic   <= dir_q[IC_LO +: HC_W];
            ent_oc   <= dir_q[OC_LO +: HC_W];
            pos      <= idx[POS_W-1:0];
            j        <= '0;
            if (cmd == CMD_ADD_IN || cmd == CMD_ADD_OUT) begin
              state <= (q_list_n == '0) ? S_APP : S_HRD;
            end else if (cmd == CMD_REMOVE) begin
              state <= S_MRD;
            end else if (dir_q[IC_LO +: HC_W] == '0) begin
              state <= S_IDLE;
              done  <= 1'b1;
            end else begin
              state <= S_IRD;
            end
          end else if (idx_inc < count) begin
            idx   <= idx_inc;
            state <= S_DRD;
          end else if (cmd == CMD_ADD_IN || cmd == CMD_ADD_OUT) begin
            if (count >= CNT_W'(MAX_DEVICES)) begin
              res_status <= ST_FULL;
              state      <= S_IDLE;
              done       <= 1'b1;
            end else begin
              state <= S_SLOT;
            end
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_SLOT: state <= S_SLOTGET;
        S_SLOTGET: begin
          count <= count + CNT_W'(1);
          if (count == hwm) begin
            hwm <= hwm + CNT_W'(1);
          end
          res_status <= ST_OK;
          state      <= S_IDLE;
          done       <= 1'b1;
        end
        S_HRD: state <= S_HCHK;
        S_HCHK: begin
          if ((is_out ? out_q.id : in_q.id) == hid &&
              (is_out ? out_q.bus : in_q.bus) == hbus) begin
            // duplicate hop, stored quality kept
            res_status <= ST_OK;
            state      <= S_IDLE;
            done       <= 1'b1;
          end else if (j_inc < list_n) begin
            j     <= j_inc;
            state <= S_HRD;
          end else begin
            state <= S_APP;
          end
        end
        S_APP: begin
          res_status <= (list_n < HC_W'(MAX_HOPS)) ? ST_OK : ST_FULL;
          state      <= S_IDLE;
          done       <= 1'b1;
        end
        S_IRD: state <= S_IGET;
        S_IGET: begin
          irec <= in_q;
          if (in_q.q < in_limit && ent_oc != '0) begin
            k     <= '0;
            state <= S_ORD;
          end else if (j_inc < ent_ic) begin
            j     <= j_inc;
            state <= S_IRD;
          end else begin
            res_status <= have ? ST_OK : ST_FAIL;
            state      <= S_IDLE;
            done       <= 1'b1;
          end
        end
        S_ORD: state <= S_OGET;
        S_OGET: begin
          if (better) begin
            have       <= 1'b1;
            best_i     <= irec.q;
            best_o     <= out_q.q;
            res_target <= ent_id;
            res_bus_t  <= out_q.bus;
            res_prev   <= irec.id;
            res_bus_p  <= irec.bus;
            res_next   <= out_q.id;
          end
          if (k_inc < ent_oc) begin
            k     <= k_inc;
            state <= S_ORD;
          end else if (j_inc < ent_ic) begin
            j     <= j_inc;
            state <= S_IRD;
          end else begin
            res_status <= have_n ? ST_OK : ST_FAIL;
            state      <= S_IDLE;
            done       <= 1'b1;
          end
        end
        S_MRD: begin
          if (idx_inc < count) begin
            state <= S_MWR;
          end else begin
            count      <= count - CNT_W'(1);
            res_status <= ST_OK;
            state      <= S_IDLE;
            done       <= 1'b1;
          end
        end
        S_MWR: begin
          idx   <= idx_inc;
          state <= S_MRD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LHTBR_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(MAX_DEVICES))
  `LHTBR_ASSERT_NOW(a_hwm_covers, clk, rst, 1'b1, hwm >= count && hwm <= CNT_W'(MAX_DEVICES))
  `LHTBR_ASSERT_NXT(a_busy_after_take, clk, rst, in_acc, in_stall)
  `LHTBR_ASSERT_NXT(a_done_delivers, clk, rst, done && !(out_valid && out_stall), out_valid && !done)

endmodule

@@ tb/last_hop_table_best_route_tb.sv @@
// self-checking bench for the last-hop table with best-route search
// depends on lhtbr_pkg and last_hop_table_best_route
`timescale 1ns / 1ps

module last_hop_table_best_route_tb
  import lhtbr_pkg::*;
();

  localparam int NDEV = DEF_MAX_DEVICES;
  localparam int NHOP = DEF_MAX_HOPS;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] target;
    logic [ID_W-1:0] bus_at_target;
    logic [ID_W-1:0] prev_id;
    logic [ID_W-1:0] bus_at_prev;
    logic [ID_W-1:0] next_id;
  } route_t;

  // scoreboard: shadow copy of the table plus queue of expected route words
  class route_scoreboard;
    logic [ID_W-1:0] dev_ids[NDEV];
    int              dev_cnt;
    hop_t            in_list[NDEV][NHOP];
    hop_t            out_list[NDEV][NHOP];
    int              in_cnt[NDEV];
    int              out_cnt[NDEV];
    logic [Q_W-1:0]  in_lim;
    logic [Q_W-1:0]  out_lim;
    route_t          pending[$];
    int              errors;
    int              checked;
    int              found;

    function new();
      dev_cnt = 0;
      in_lim = LIMIT_RESET;
      out_lim = LIMIT_RESET;
      errors = 0;
      checked = 0;
      found = 0;
    endfunction

    function void set_limit(logic [0:0] idx, logic [Q_W-1:0] val);
      if (idx == REG_IN_LIMIT) in_lim = val;
      else out_lim = val;
    endfunction

    function int lookup(logic [ID_W-1:0] dev);
      for (int i = 0; i < dev_cnt; i++)
        if (dev_ids[i] == dev) return i;
      return dev_cnt;
    endfunction

    function logic [1:0] add_hop(bit outgoing, logic [ID_W-1:0] dev, hop_t h);
      int d;
      int n;
      d = lookup(dev);
      if (d >= dev_cnt) begin
        if (dev_cnt >= NDEV) return ST_FULL;
        d = dev_cnt;
        dev_ids[d] = dev;
        in_cnt[d] = 0;
        out_cnt[d] = 0;
        dev_cnt++;
      end
      n = outgoing ? out_cnt[d] : in_cnt[d];
      for (int j = 0; j < n; j++) begin
        if (outgoing && out_list[d][j].id == h.id && out_list[d][j].bus == h.bus) return ST_OK;
        if (!outgoing && in_list[d][j].id == h.id && in_list[d][j].bus == h.bus) return ST_OK;
      end
      if (n >= NHOP) return ST_FULL;
      if (outgoing) begin
        out_list[d][n] = h;
        out_cnt[d]++;
      end else begin
        in_list[d][n] = h;
        in_cnt[d]++;
      end
      return ST_OK;
    endfunction

    function route_t best_route(logic [ID_W-1:0] dev);
      route_t r;
      int d;
      bit have;
      logic [Q_W-1:0] bi;
      logic [Q_W-1:0] bo;
      r = '0;
      have = 1'b0;
      bi = '0;
      bo = '0;
      d = lookup(dev);
      r.status = ST_FAIL;
      if (d >= dev_cnt) return r;
      for (int j = 0; j < in_cnt[d]; j++) begin
        if (in_list[d][j].q >= in_lim) continue;
        for (int k = 0; k < out_cnt[d]; k++) begin
          if (in_list[d][j].id != out_list[d][k].id || out_list[d][k].q >= out_lim) continue;
          if (!have || in_list[d][j].q < bi || (in_list[d][j].q == bi && out_list[d][k].q < bo))
          begin
            have = 1'b1;
            bi = in_list[d][j].q;
            bo = out_list[d][k].q;
            r.status = ST_OK;
            r.target = dev;
            r.bus_at_target = out_list[d][k].bus;
            r.prev_id = in_list[d][j].id;
            r.bus_at_prev = in_list[d][j].bus;
            r.next_id = out_list[d][k].id;
          end
        end
      end
      return r;
    endfunction

    function logic [1:0] drop_device(logic [ID_W-1:0] dev);
      int d;
      d = lookup(dev);
      if (d >= dev_cnt) return ST_FAIL;
      for (int i = d; i + 1 < dev_cnt; i++) begin
        dev_ids[i] = dev_ids[i+1];
        in_cnt[i] = in_cnt[i+1];
        out_cnt[i] = out_cnt[i+1];
        in_list[i] = in_list[i+1];
        out_list[i] = out_list[i+1];
      end
      dev_cnt--;
      return ST_OK;
    endfunction

    function void note_command(logic [2:0] cmd, logic [ID_W-1:0] dev, hop_t h);
      route_t r;
      r = '0;
      case (cmd)
        CMD_ADD_IN:  r.status = add_hop(1'b0, dev, h);
        CMD_ADD_OUT: r.status = add_hop(1'b1, dev, h);
        CMD_FIND:    r = best_route(dev);
        CMD_FIND_FIRST: begin
          if (dev_cnt == 0) r.status = ST_FAIL;
          else r = best_route(dev_ids[0]);
        end
        CMD_REMOVE:  r.status = drop_device(dev);
        default:     r.status = ST_FAIL;
      endcase
      pending = {pending, r};
    endfunction

    function void check_route(route_t got);
      route_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected result word status=%0d", got.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.status == ST_OK && e.target != 0) found++;
      if (got.status != e.status) begin
        $error("status expected %0d actual %0d", e.status, got.status); errors++;
      end
      if (got.target != e.target) begin
        $error("target expected %0h actual %0h", e.target, got.target); errors++;
      end
      if (got.bus_at_target != e.bus_at_target) begin
        $error("bus_at_target expected %0h actual %0h", e.bus_at_target, got.bus_at_target);
        errors++;
      end
      if (got.prev_id != e.prev_id) begin
        $error("prev_id expected %0h actual %0h", e.prev_id, got.prev_id); errors++;
      end
      if (got.bus_at_prev != e.bus_at_prev) begin
        $error("bus_at_prev expected %0h actual %0h", e.bus_at_prev, got.bus_at_prev); errors++;
      end
      if (got.next_id != e.next_id) begin
        $error("next_id expected %0h actual %0h", e.next_id, got.next_id); errors++;
      end
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_stall;
  logic [2:0]      command;
  logic [ID_W-1:0] device;
  logic [ID_W-1:0] hop_id;
  logic [ID_W-1:0] hop_bus_id;
  logic [Q_W-1:0]  quality;
  logic            out_valid;
  logic            out_stall;
  logic [1:0]      status;
  logic [ID_W-1:0] target;
  logic [ID_W-1:0] bus_at_target;
  logic [ID_W-1:0] prev_id;
  logic [ID_W-1:0] bus_at_prev;
  logic [ID_W-1:0] next_id;
  logic            cfg_we;
  logic [0:0]      cfg_index;
  logic [Q_W-1:0]  cfg_data;

  last_hop_table_best_route dut (.*);

  route_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off;
  int sent;
  // small pools keep ids colliding so pairs match and lists fill
  logic [ID_W-1:0] dev_pool[6];
  logic [ID_W-1:0] hop_pool[5];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: random stall, plus a long hold-off on request
  int hold_cnt;
  initial begin
    out_stall = 1'b1;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        hold_cnt++;
        if (hold_cnt >= 3000) begin
          hold_off = 1'b0;
          hold_cnt = 0;
        end
      end else
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      sb.check_route('{status, target, bus_at_target, prev_id, bus_at_prev, next_id});

  task automatic send_word(logic [2:0] cmd, logic [ID_W-1:0] dev, logic [ID_W-1:0] hid,
                           logic [ID_W-1:0] bus, logic [Q_W-1:0] q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    device <= dev;
    hop_id <= hid;
    hop_bus_id <= bus;
    quality <= q;
    do @(posedge clk); while (in_stall);
    sb.note_command(cmd, dev, '{hid, bus, q});
    sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (400) @(posedge clk);
  endtask

  task automatic write_limit(logic [0:0] idx, logic [Q_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_limit(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_word();
    int pick;
    logic [ID_W-1:0] dev;
    logic [ID_W-1:0] hid;
    pick = $urandom_range(99);
    dev = ($urandom_range(9) == 0) ? 16'($urandom) : dev_pool[$urandom_range(5)];
    hid = ($urandom_range(9) == 0) ? 16'($urandom) : hop_pool[$urandom_range(4)];
    if (pick < 35)
      send_word(CMD_ADD_IN, dev, hid, 16'($urandom_range(3)) ^ 16'($urandom & 16'hfff0),
                8'($urandom));
    else if (pick < 70)
      send_word(CMD_ADD_OUT, dev, hid, 16'($urandom), 8'($urandom));
    else if (pick < 83) send_word(CMD_FIND, dev, hid, '0, '0);
    else if (pick < 91) send_word(CMD_FIND_FIRST, 16'($urandom), 16'($urandom), '0, '0);
    else if (pick < 97) send_word(CMD_REMOVE, dev, '0, '0, '0);
    else send_word(3'($urandom_range(7, 5)), 16'($urandom), 16'($urandom), 16'($urandom),
                   8'($urandom));
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_ADD_IN;
    device = '0;
    hop_id = '0;
    hop_bus_id = '0;
    quality = '0;
    cfg_we = 1'b0;
    cfg_index = REG_IN_LIMIT;
    cfg_data = '0;
    hold_off = 1'b0;
    sent = 0;
    send_idle_pct = 17;
    recv_idle_pct = 80;
    foreach (dev_pool[i]) dev_pool[i] = 16'($urandom);
    dev_pool[0] = 16'h0000;
    dev_pool[1] = 16'hffff;
    foreach (hop_pool[i]) hop_pool[i] = 16'($urandom);
    hop_pool[0] = 16'hffff;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extremes, duplicates, full lists, full table
    send_word(CMD_FIND_FIRST, '0, '0, '0, '0);
    send_word(CMD_FIND, 16'hffff, '0, '0, '0);
    send_word(CMD_REMOVE, 16'h1234, '0, '0, '0);
    send_word(CMD_ADD_IN, 16'hffff, 16'hffff, 16'hffff, 8'hff);
    send_word(CMD_ADD_OUT, 16'hffff, 16'hffff, 16'h0000, 8'h00);
    send_word(CMD_FIND, 16'hffff, '0, '0, '0);
    send_word(CMD_ADD_IN, 16'hffff, 16'hffff, 16'h0000, 8'h7e);
    send_word(CMD_ADD_IN, 16'hffff, 16'hffff, 16'h0000, 8'h01);
    send_word(CMD_FIND_FIRST, '0, '0, '0, '0);
    send_word(CMD_ADD_OUT, 16'h0000, 16'h0000, 16'hffff, 8'h7f);
    send_word(CMD_FIND, 16'h0000, '0, '0, '0);
    for (int i = 0; i < NHOP + 1; i++)
      send_word(CMD_ADD_IN, 16'h0000, 16'(i), 16'(i), 8'(i));
    for (int i = 0; i < NDEV; i++)
      send_word(CMD_ADD_OUT, 16'(100 + i), 16'h0001, 16'h0002, 8'h03);
    send_word(CMD_REMOVE, 16'hffff, '0, '0, '0);
    send_word(3'd7, 16'hffff, 16'hffff, 16'hffff, 8'hff);
    drain();
    // clear the table, oldest device first
    for (int i = 0; i < NDEV; i++)
      if (sb.dev_cnt > 0) send_word(CMD_REMOVE, sb.dev_ids[0], '0, '0, '0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_limit(REG_IN_LIMIT, 8'hff); write_limit(REG_OUT_LIMIT, 8'hff); end
        1: begin write_limit(REG_IN_LIMIT, 8'h00); write_limit(REG_OUT_LIMIT, 8'h80); end
        2: begin write_limit(REG_IN_LIMIT, 8'h80); write_limit(REG_OUT_LIMIT, 8'h00); end
        3: begin send_idle_pct = 80; recv_idle_pct = 17; end
        4: begin
          write_limit(REG_IN_LIMIT, 8'($urandom));
          write_limit(REG_OUT_LIMIT, 8'($urandom));
        end
        default: begin
          send_idle_pct = 0; recv_idle_pct = 0;
          write_limit(REG_IN_LIMIT, LIMIT_RESET); write_limit(REG_OUT_LIMIT, LIMIT_RESET);
        end
      endcase
      if (phase == 5) hold_off = 1'b1;
      for (int i = 0; i < 105; i++) random_word();
      // empty out the pool devices once, in phase 2, so the table churns
      if (phase == 2)
        for (int i = 0; i < 6; i++) send_word(CMD_REMOVE, dev_pool[i], '0, '0, '0);
      drain();
    end

    $display("sent %0d command words, checked %0d results, %0d routes found",
             sent, sb.checked, sb.found);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
